// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the decaying square tone FIFO.
// Included by bare file name; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, disabled while the active-low reset is low.
`define DSTF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same check without a reset qualifier.
`define DSTF_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/dstf_pkg.sv =====
// Package of the decaying square tone FIFO: widths, defaults, codes and payload types.
// Depends on nothing; used by every other file of the block but assert_macros.svh.
`default_nettype none

package dstf_pkg;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned LEN_W      = 15;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned DECAY_W    = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned PROD_W     = 2 * DECAY_W;

  localparam int unsigned DEPTH_DEF    = 32768;
  localparam int unsigned HEADROOM_DEF = 256;
  localparam int unsigned MAX_READ_DEF = 64;

  localparam logic [DECAY_W-1:0] AMPLITUDE = 16'd8000;
  localparam logic [DECAY_W-1:0] ENV_START = 16'hFFFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TONE    = 2'd0,
    FUNC_SILENCE = 2'd1,
    FUNC_READ    = 2'd2
  } dstf_func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_ENV,
    ST_SIL,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_RESP
  } dstf_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [LEN_W-1:0]   length;
    logic [PHASE_W-1:0] phase_step;
    logic [DECAY_W-1:0] decay_factor;
  } dstf_in_t;

  typedef struct packed {
    logic                       status;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic                       last;
  } dstf_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/dstf_if.sv =====
// Request and result channel interfaces of the decaying square tone FIFO.
// Depends on dstf_pkg for the payload types.
`default_nettype none

interface dstf_in_if;
  logic               valid;
  logic               ready;
  dstf_pkg::dstf_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface dstf_out_if;
  logic                valid;
  logic                ready;
  dstf_pkg::dstf_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dstf_mul.sv =====
// Shared 16 x 16 unsigned multiplier with a registered product.
// Depends on dstf_pkg for the operand widths.
`default_nettype none

module dstf_mul (
  input  logic                              clk_i,
  input  logic [dstf_pkg::DECAY_W-1:0]      a_i,
  input  logic [dstf_pkg::DECAY_W-1:0]      b_i,
  output logic [dstf_pkg::PROD_W-1:0]       prod_o
);

  logic [dstf_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= dstf_pkg::PROD_W'(a_i) * dstf_pkg::PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== rtl/core/dstf_store.sv =====
// Sample memory: one write port and one read port with registered read data.
// Depends on dstf_pkg for the sample width.
`default_nettype none

module dstf_store #(
  parameter int unsigned DEPTH = dstf_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [dstf_pkg::SAMPLE_W-1:0]  wdata_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [dstf_pkg::SAMPLE_W-1:0]  rdata_o
);

  logic [dstf_pkg::SAMPLE_W-1:0] mem_q [DEPTH];
  logic [dstf_pkg::SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/decaying_square_tone_fifo.sv =====
// Top level of the decaying square tone FIFO: sequencer, pointers and result register.
// Depends on dstf_pkg, dstf_if, dstf_mul, dstf_store and assert_macros.svh.
//
//   Channel  Dir  Modport  Moves
//   in_i     in   sink     one command request (func, length, phase_step, decay_factor)
//   out_o    out  source   one result (status, sample, sample_valid, last)
//
// Per sample, a tone request passes ST_MAG and then ST_ENV, as the one multiplier
// computes the magnitude and then the next envelope. Silence writes a sample in each
// ST_SIL pass; a read passes ST_RD_ADDR, set by the registered memory read, then
// ST_RD_DATA per popped sample. Rejected, empty and unused requests go to ST_RESP.
// Reset clears the pointers and the sequencer; the memory needs no clearing pass.
// A stalled result holds the sequencer in its emitting state; a request is taken
// only when the sequencer is idle.
`default_nettype none
`include "assert_macros.svh"

module decaying_square_tone_fifo #(
  parameter int unsigned DEPTH    = dstf_pkg::DEPTH_DEF,
  parameter int unsigned HEADROOM = dstf_pkg::HEADROOM_DEF,
  parameter int unsigned MAX_READ = dstf_pkg::MAX_READ_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dstf_in_if.sink        in_i,
  dstf_out_if.source     out_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LEN_W = dstf_pkg::LEN_W;
  localparam int unsigned CW    = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam int unsigned SW    = dstf_pkg::SAMPLE_W;
  localparam int unsigned DW    = dstf_pkg::DECAY_W;
  localparam int unsigned PW    = dstf_pkg::PHASE_W;

  dstf_pkg::dstf_state_e state_q, state_d;
  logic [LEN_W-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]         wp_q, wp_d, rp_q, rp_d;
  logic                  first_q, first_d;
  logic                  status_q, status_d;
  logic                  out_valid_q, out_valid_d;
  dstf_pkg::dstf_out_t   out_q, out_d;
  logic [PW-1:0]         phase_q, phase_d, step_q, step_d;
  logic [DW-1:0]         decay_q, decay_d, env_q, env_d;

  logic [DW-1:0]            mul_a, mul_b, env_cur, mag;
  logic [dstf_pkg::PROD_W-1:0] prod;
  logic                     we;
  logic [SW-1:0]            wdata, rdata;
  logic [CW-1:0]            fill, len_ext, n_rd;
  logic [LEN_W-1:0]         cap;
  logic                     reject, slot_free, out_load, in_accept;
  dstf_pkg::dstf_out_t      out_new;

  dstf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  dstf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (wdata),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    next_slot = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // Fill level and admission checks for the request at the port.
  always_comb begin
    if (wp_q >= rp_q) begin
      fill = CW'(wp_q) - CW'(rp_q);
    end else begin
      fill = CW'(DEPTH) - CW'(rp_q) + CW'(wp_q);
    end
    len_ext = CW'(in_i.payload.length);
    reject  = (in_i.payload.length == '0) || (len_ext > CW'(DEPTH - HEADROOM)) ||
              ((fill + len_ext) >= CW'(DEPTH));
    cap     = (in_i.payload.length < LEN_W'(MAX_READ)) ? in_i.payload.length
                                                       : LEN_W'(MAX_READ);
    n_rd    = (fill < CW'(cap)) ? fill : CW'(cap);
  end

  assign slot_free    = !out_valid_q || out_o.ready;
  assign in_i.ready   = (state_q == dstf_pkg::ST_IDLE);
  assign in_accept    = in_i.valid && in_i.ready;
  assign env_cur      = first_q ? dstf_pkg::ENV_START : prod[dstf_pkg::PROD_W-1:DW];
  assign mag          = prod[dstf_pkg::PROD_W-1:DW];

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    first_d  = first_q;
    status_d = status_q;
    phase_d  = phase_q;
    step_d   = step_q;
    decay_d  = decay_q;
    env_d    = env_q;
    mul_a    = env_q;
    mul_b    = decay_q;
    we       = 1'b0;
    wdata    = '0;
    out_load = 1'b0;
    out_new  = '{status: status_q, sample: '0, sample_valid: 1'b0, last: 1'b1};

    unique case (state_q)
      dstf_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          step_d   = in_i.payload.phase_step;
          decay_d  = in_i.payload.decay_factor;
          phase_d  = '0;
          first_d  = 1'b1;
          status_d = 1'b0;
          unique case (in_i.payload.func)
            dstf_pkg::FUNC_TONE, dstf_pkg::FUNC_SILENCE: begin
              if (reject) begin
                status_d = 1'b1;
                state_d  = dstf_pkg::ST_RESP;
              end else begin
                cnt_d   = in_i.payload.length;
                state_d = (in_i.payload.func == dstf_pkg::FUNC_TONE) ? dstf_pkg::ST_MAG
                                                                      : dstf_pkg::ST_SIL;
              end
            end
            dstf_pkg::FUNC_READ: begin
              if (n_rd == '0) begin
                state_d = dstf_pkg::ST_RESP;
              end else begin
                cnt_d   = LEN_W'(n_rd);
                state_d = dstf_pkg::ST_RD_ADDR;
              end
            end
            default: begin
              status_d = 1'b1;
              state_d  = dstf_pkg::ST_RESP;
            end
          endcase
        end
      end
      dstf_pkg::ST_MAG: begin
        // The product register holds the envelope update of the previous sample.
        env_d   = env_cur;
        mul_a   = env_cur;
        mul_b   = dstf_pkg::AMPLITUDE;
        first_d = 1'b0;
        state_d = dstf_pkg::ST_ENV;
      end
      dstf_pkg::ST_ENV: begin
        we      = 1'b1;
        wdata   = phase_q[PW-1] ? (SW'(0) - SW'(mag)) : SW'(mag);
        wp_d    = next_slot(wp_q);
        mul_a   = env_q;
        mul_b   = decay_q;
        phase_d = phase_q + step_q;
        cnt_d   = cnt_q - LEN_W'(1);
        state_d = (cnt_q == LEN_W'(1)) ? dstf_pkg::ST_RESP : dstf_pkg::ST_MAG;
      end
      dstf_pkg::ST_SIL: begin
        we      = 1'b1;
        wp_d    = next_slot(wp_q);
        cnt_d   = cnt_q - LEN_W'(1);
        state_d = (cnt_q == LEN_W'(1)) ? dstf_pkg::ST_RESP : dstf_pkg::ST_SIL;
      end
      dstf_pkg::ST_RD_ADDR: begin
        // Lets the memory's read register catch up with the read pointer.
        state_d = dstf_pkg::ST_RD_DATA;
      end
      dstf_pkg::ST_RD_DATA: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_new  = '{status: 1'b0, sample: $signed(rdata), sample_valid: 1'b1,
                       last: (cnt_q == LEN_W'(1))};
          rp_d     = next_slot(rp_q);
          cnt_d    = cnt_q - LEN_W'(1);
          state_d  = (cnt_q == LEN_W'(1)) ? dstf_pkg::ST_IDLE : dstf_pkg::ST_RD_ADDR;
        end
      end
      dstf_pkg::ST_RESP: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = dstf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dstf_pkg::ST_IDLE;
      end
    endcase

    out_d       = out_load ? out_new : out_q;
    out_valid_d = out_load || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dstf_pkg::ST_IDLE;
      cnt_q       <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      first_q     <= 1'b1;
      status_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      first_q     <= first_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    phase_q <= phase_d;
    step_q  <= step_d;
    decay_q <= decay_d;
    env_q   <= env_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  `DSTF_ASSERT(a_pop_not_empty, clk_i, rst_ni, (out_load && out_new.sample_valid) |-> (wp_q != rp_q), "sample popped from an empty buffer")
  `DSTF_ASSERT(a_no_overfill, clk_i, rst_ni, we |=> (wp_q != rp_q), "append filled the buffer completely")
  `DSTF_ASSERT(a_accept_busy, clk_i, rst_ni, in_accept |=> (state_q != dstf_pkg::ST_IDLE), "accepted request left the sequencer idle")

endmodule

`default_nettype wire

// ===== test/tb_decaying_square_tone_fifo.sv =====
`timescale 1ns / 1ps
// Testbench of decaying_square_tone_fifo: directed, random and stress requests with checks.
// Depends on dstf_pkg, dstf_if and the RTL of the block; predicts every result itself.

module tb_decaying_square_tone_fifo;

  localparam int unsigned FIFO_DEPTH = dstf_pkg::DEPTH_DEF;
  localparam int unsigned APPEND_MAX = dstf_pkg::DEPTH_DEF - dstf_pkg::HEADROOM_DEF;
  localparam int unsigned READ_CAP   = dstf_pkg::MAX_READ_DEF;
  localparam int unsigned LEN_MAX    = (1 << dstf_pkg::LEN_W) - 1;
  localparam logic [dstf_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;

  dstf_in_if  req_ch ();
  dstf_out_if rsp_ch ();

  decaying_square_tone_fifo u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  // Mirror of the sample ring and the results still owed by the block.
  logic [dstf_pkg::SAMPLE_W-1:0] sample_mirror [0:FIFO_DEPTH-1];
  int unsigned                   mirror_wr;
  int unsigned                   mirror_rd;
  dstf_pkg::dstf_out_t           pending_results [$];

  int unsigned         mismatch_count;
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;
  int unsigned         hold_len;
  int unsigned         hold_tag;
  dstf_pkg::dstf_out_t got_result;
  dstf_pkg::dstf_out_t want_result;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned mirror_fill();
    return (mirror_wr + FIFO_DEPTH - mirror_rd) % FIFO_DEPTH;
  endfunction

  function automatic void owe_result(input logic st,
                                     input logic [dstf_pkg::SAMPLE_W-1:0] smp,
                                     input logic vld, input logic lst);
    dstf_pkg::dstf_out_t res;
    res.status       = st;
    res.sample       = smp;
    res.sample_valid = vld;
    res.last         = lst;
    pending_results.push_back(res);
  endfunction

  // Applies one accepted request to the mirror and queues the results it owes.
  function automatic void apply_request(input dstf_pkg::dstf_in_t req);
    int unsigned                   len;
    int unsigned                   count;
    logic [31:0]                   phase;
    logic [31:0]                   env;
    logic [31:0]                   prod;
    logic [dstf_pkg::SAMPLE_W-1:0] smp;
    len = req.length;
    case (req.func)
      dstf_pkg::FUNC_TONE, dstf_pkg::FUNC_SILENCE: begin
        if (len == 0 || len > APPEND_MAX || mirror_fill() + len >= FIFO_DEPTH) begin
          owe_result(1'b1, '0, 1'b0, 1'b1);
        end else begin
          phase = '0;
          env   = 32'(dstf_pkg::ENV_START);
          for (int unsigned i = 0; i < len; i++) begin
            smp = '0;
            if (req.func == dstf_pkg::FUNC_TONE) begin
              prod  = env * 32'(dstf_pkg::AMPLITUDE);
              smp   = phase[31] ? (16'd0 - prod[31:16]) : prod[31:16];
              phase = phase + req.phase_step;
              env   = (env * 32'(req.decay_factor)) >> 16;
            end
            sample_mirror[mirror_wr] = smp;
            mirror_wr = (mirror_wr + 1) % FIFO_DEPTH;
          end
          owe_result(1'b0, '0, 1'b0, 1'b1);
        end
      end
      dstf_pkg::FUNC_READ: begin
        count = mirror_fill();
        if (count > len) count = len;
        if (count > READ_CAP) count = READ_CAP;
        if (count == 0) begin
          owe_result(1'b0, '0, 1'b0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < count; i++) begin
            owe_result(1'b0, sample_mirror[mirror_rd], 1'b1, i + 1 == count);
            mirror_rd = (mirror_rd + 1) % FIFO_DEPTH;
          end
        end
      end
      default: begin
        owe_result(1'b1, '0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // Offers one request, idling the channel at random first, and waits for acceptance.
  task automatic send_req(input logic [dstf_pkg::FUNC_W-1:0] func, input int unsigned len,
                          input logic [dstf_pkg::PHASE_W-1:0] step,
                          input logic [dstf_pkg::DECAY_W-1:0] decay);
    dstf_pkg::dstf_in_t req;
    req.func         = func;
    req.length       = dstf_pkg::LEN_W'(len);
    req.phase_step   = step;
    req.decay_factor = decay;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= req;
    do @(posedge clk_i); while (!req_ch.ready);
    apply_request(req);
  endtask

  task automatic wait_results_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_edges();
    send_req(dstf_pkg::FUNC_READ, 5, 32'h0, 16'h0);
    send_req(FUNC_UNUSED, 7, 32'h1234_5678, 16'hABCD);
    send_req(dstf_pkg::FUNC_TONE, 0, 32'h1000_0000, 16'hF000);
    send_req(dstf_pkg::FUNC_SILENCE, 0, 32'h0, 16'h0);
    send_req(dstf_pkg::FUNC_TONE, LEN_MAX, 32'h1000_0000, 16'hF000);
    send_req(dstf_pkg::FUNC_SILENCE, APPEND_MAX + 1, 32'h0, 16'h0);
    send_req(dstf_pkg::FUNC_TONE, 12, 32'h4000_0000, 16'hF000);
    // A zero decay leaves only the first sample nonzero.
    send_req(dstf_pkg::FUNC_TONE, 6, 32'hFFFF_FFFF, 16'h0000);
    send_req(dstf_pkg::FUNC_TONE, 5, 32'h0000_0000, 16'hFFFF);
    send_req(dstf_pkg::FUNC_TONE, 8, 32'h8000_0000, 16'h8000);
    send_req(dstf_pkg::FUNC_SILENCE, 3, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(dstf_pkg::FUNC_SILENCE, 250, 32'h0, 16'h0);
    // The length alone is legal here; the fill level makes it overflow.
    send_req(dstf_pkg::FUNC_TONE, APPEND_MAX, 32'h0100_0000, 16'hFF00);
    send_req(dstf_pkg::FUNC_READ, 0, 32'h0, 16'h0);
    send_req(dstf_pkg::FUNC_READ, 1, 32'h0, 16'h0);
    send_req(dstf_pkg::FUNC_READ, LEN_MAX, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(dstf_pkg::FUNC_READ, READ_CAP, 32'h0, 16'h0);
    send_req(dstf_pkg::FUNC_READ, READ_CAP - 1, 32'h0, 16'h0);
    send_req(dstf_pkg::FUNC_READ, 100, 32'h0, 16'h0);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned                      pick;
    int unsigned                      sub;
    int unsigned                      len;
    logic [dstf_pkg::FUNC_W-1:0]      func;
    logic [dstf_pkg::PHASE_W-1:0]     step;
    logic [dstf_pkg::DECAY_W-1:0]     decay;
    for (int unsigned k = 0; k < count; k++) begin
      pick  = $urandom_range(99);
      sub   = $urandom_range(9);
      step  = ($urandom_range(1) == 1) ? $urandom() : $urandom_range(32'h1000_0000);
      decay = ($urandom_range(1) == 1) ?
              dstf_pkg::DECAY_W'($urandom()) :
              dstf_pkg::DECAY_W'($urandom_range(16'hFFFF, 16'hE000));
      if (mirror_fill() > 1500) pick = 0;
      if (pick < 40) begin
        func = dstf_pkg::FUNC_READ;
        len  = (sub == 0) ? 0 : (sub == 1) ? $urandom_range(LEN_MAX) : $urandom_range(1, 64);
      end else if (pick < 70) begin
        func = dstf_pkg::FUNC_TONE;
        len  = (sub == 0) ? $urandom_range(65, 300) : $urandom_range(1, 48);
      end else if (pick < 85) begin
        func = dstf_pkg::FUNC_SILENCE;
        len  = $urandom_range(1, 64);
      end else if (pick < 92) begin
        func = FUNC_UNUSED;
        len  = $urandom_range(LEN_MAX);
      end else begin
        func = ($urandom_range(1) == 1) ? dstf_pkg::FUNC_TONE : dstf_pkg::FUNC_SILENCE;
        len  = (sub < 3) ? 0 : $urandom_range(APPEND_MAX + 1, LEN_MAX);
      end
      send_req(func, len, step, decay);
    end
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // block has to hold its input off.
  task automatic test_receiver_hold();
    hold_len <= 1500;
    hold_tag <= hold_tag + 1;
    send_req(dstf_pkg::FUNC_SILENCE, 40, 32'h0, 16'h0);
    send_req(dstf_pkg::FUNC_TONE, 30, 32'h0800_0000, 16'hFA00);
    send_req(dstf_pkg::FUNC_READ, READ_CAP, 32'h0, 16'h0);
    send_req(dstf_pkg::FUNC_TONE, 10, 32'hC000_0000, 16'h7FFF);
    send_req(dstf_pkg::FUNC_READ, 20, 32'h0, 16'h0);
    send_req(FUNC_UNUSED, 3, 32'h0, 16'h0);
    send_req(dstf_pkg::FUNC_READ, READ_CAP, 32'h0, 16'h0);
  endtask

  task automatic test_sender_pause();
    send_req(dstf_pkg::FUNC_TONE, 20, 32'h2000_0000, 16'hF800);
    send_req(dstf_pkg::FUNC_READ, 7, 32'h0, 16'h0);
    wait_results_drained();
    send_req(dstf_pkg::FUNC_READ, READ_CAP, 32'h0, 16'h0);
    send_req(dstf_pkg::FUNC_SILENCE, 2, 32'h0, 16'h0);
    wait_results_drained();
    send_req(dstf_pkg::FUNC_READ, READ_CAP, 32'h0, 16'h0);
  endtask

  // Fills the ring to one below full and probes the boundary there; the write
  // pointer wraps on the way. A few reads then make room for one more tone.
  task automatic test_full_buffer();
    while (mirror_fill() != 0) send_req(dstf_pkg::FUNC_READ, READ_CAP, 32'h0, 16'h0);
    send_req(dstf_pkg::FUNC_SILENCE, APPEND_MAX, 32'h0, 16'h0);
    send_req(dstf_pkg::FUNC_TONE, dstf_pkg::HEADROOM_DEF, 32'h0400_0000, 16'hFFF0);
    send_req(dstf_pkg::FUNC_TONE, dstf_pkg::HEADROOM_DEF - 1, 32'h0400_0000, 16'hFFF0);
    send_req(dstf_pkg::FUNC_SILENCE, 1, 32'h0, 16'h0);
    send_req(dstf_pkg::FUNC_TONE, 40, $urandom(), 16'hF000);
    repeat (3) begin
      send_req(dstf_pkg::FUNC_READ, $urandom_range(READ_CAP, LEN_MAX), 32'h0, 16'h0);
    end
    send_req(dstf_pkg::FUNC_TONE, 40, $urandom(), 16'hF000);
    send_req(dstf_pkg::FUNC_READ, READ_CAP, 32'h0, 16'h0);
  endtask

  // Receiver: random ready, or a long hold-off counted here when one is asked for.
  initial begin : receiver
    int unsigned hold_cnt;
    int unsigned seen_tag;
    hold_cnt = 0;
    seen_tag = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_tag != seen_tag) begin
        seen_tag = hold_tag;
        hold_cnt = hold_len;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got_result = rsp_ch.payload;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, actual st=%0b smp=%0d v=%0b l=%0b",
                 $time, got_result.status, got_result.sample, got_result.sample_valid,
                 got_result.last);
        mismatch_count++;
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.status !== want_result.status ||
            got_result.sample !== want_result.sample ||
            got_result.sample_valid !== want_result.sample_valid ||
            got_result.last !== want_result.last) begin
          $display(
            "%0t: expected st=%0b smp=%0d v=%0b l=%0b, actual st=%0b smp=%0d v=%0b l=%0b",
            $time, want_result.status, want_result.sample, want_result.sample_valid,
            want_result.last, got_result.status, got_result.sample,
            got_result.sample_valid, got_result.last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    mirror_wr      = 0;
    mirror_rd      = 0;
    send_idle_pct  = 28;
    recv_idle_pct  = 75;
    hold_len      <= 0;
    hold_tag      <= 0;
    rst_ni        <= 1'b0;
    req_ch.valid  <= 1'b0;
    req_ch.payload <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_random_traffic(100);

    send_idle_pct = 75;
    recv_idle_pct = 28;
    test_receiver_hold();
    test_random_traffic(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_sender_pause();
    test_random_traffic(85);
    test_full_buffer();

    wait_results_drained();
    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
